### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/qvr_pkg.sv
package qvr_pkg;

  localparam int VEC_W   = 24;
  localparam int ROT_W   = 16;
  localparam int FRAC_W  = 14;
  localparam int STAGES  = 5;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_W = 2'd3;

  localparam logic signed [ROT_W-1:0] ROT_W_RESET = 16'sd16384;

  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef struct packed {
    logic [VEC_W-1:0] vec_x;
    logic [VEC_W-1:0] vec_y;
    logic [VEC_W-1:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic [VEC_W-1:0] out_x;
    logic [VEC_W-1:0] out_y;
    logic [VEC_W-1:0] out_z;
    logic             clipped;
  } vec_out_t;

endpackage

### hdl/qvr_stream_if.sv
interface qvr_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/quaternion_vector_rotate.sv
// Five register stages lie between an input transaction and its result valid (products,
// first cross shift, second products, sums, saturation).
// Throughput: one vector per cycle unless the output stalls; each stage advances on its own, so bubbles
// close up and a stalled output only backs up the stages that are full.
// Reset (rst_n low, synchronous): all stage valid bits clear, quaternion set to (0,0,0,1.0).
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  qvr_stream_if.sink                  in_ch,
  qvr_stream_if.source                out_ch,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_idx,
  input  logic [ROT_W-1:0]            cfg_wdata
);

  localparam int P1_W  = ROT_W + VEC_W;        // rot * vec
  localparam int UV_W  = P1_W + 1 - FRAC_W;    // shifted first cross
  localparam int P3_W  = ROT_W + UV_W;         // rot * uv
  localparam int PW_W  = ROT_W + 1 + UV_W;     // 2*rot_w * uv
  localparam int UUV_W = P3_W + 1 - FRAC_W;    // shifted second cross
  localparam int WT_W  = PW_W - FRAC_W;        // shifted w term
  localparam int SUM_W = UUV_W + 3;

  logic signed [ROT_W-1:0] rot_x_r, rot_y_r, rot_z_r, rot_w_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= '0;
      rot_y_r <= '0;
      rot_z_r <= '0;
      rot_w_r <= ROT_W_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROT_X: rot_x_r <= $signed(cfg_wdata);
        REG_ROT_Y: rot_y_r <= $signed(cfg_wdata);
        REG_ROT_Z: rot_z_r <= $signed(cfg_wdata);
        REG_ROT_W: rot_w_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Per-stage flow control: a stage loads when empty or when its successor loads
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || out_ch.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: first cross product terms
  logic signed [VEC_W-1:0] vx, vy, vz;
  logic signed [VEC_W-1:0] v1x_r, v1y_r, v1z_r;
  logic signed [P1_W-1:0]  p1_yz_r, p1_zy_r, p1_zx_r, p1_xz_r, p1_xy_r, p1_yx_r;

  assign vx = $signed(in_ch.data.vec_x);
  assign vy = $signed(in_ch.data.vec_y);
  assign vz = $signed(in_ch.data.vec_z);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      v1x_r   <= vx;
      v1y_r   <= vy;
      v1z_r   <= vz;
      p1_yz_r <= rot_y_r * vz;
      p1_zy_r <= rot_z_r * vy;
      p1_zx_r <= rot_z_r * vx;
      p1_xz_r <= rot_x_r * vz;
      p1_xy_r <= rot_x_r * vy;
      p1_yx_r <= rot_y_r * vx;
    end
  end

  // Stage 2: differences, floor shift to uv
  logic signed [P1_W:0]    d1x, d1y, d1z;
  logic signed [VEC_W-1:0] v2x_r, v2y_r, v2z_r;
  logic signed [UV_W-1:0]  uvx_r, uvy_r, uvz_r;

  assign d1x = (P1_W+1)'(p1_yz_r) - (P1_W+1)'(p1_zy_r);
  assign d1y = (P1_W+1)'(p1_zx_r) - (P1_W+1)'(p1_xz_r);
  assign d1z = (P1_W+1)'(p1_xy_r) - (P1_W+1)'(p1_yx_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      v2x_r <= v1x_r;
      v2y_r <= v1y_r;
      v2z_r <= v1z_r;
      uvx_r <= d1x[P1_W:FRAC_W];
      uvy_r <= d1y[P1_W:FRAC_W];
      uvz_r <= d1z[P1_W:FRAC_W];
    end
  end

  // Stage 3: second cross product terms and w scaling
  logic signed [ROT_W:0]   w2;
  logic signed [VEC_W-1:0] v3x_r, v3y_r, v3z_r;
  logic signed [P3_W-1:0]  p3_yz_r, p3_zy_r, p3_zx_r, p3_xz_r, p3_xy_r, p3_yx_r;
  logic signed [PW_W-1:0]  pwx_r, pwy_r, pwz_r;

  assign w2 = {rot_w_r, 1'b0};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      v3x_r   <= v2x_r;
      v3y_r   <= v2y_r;
      v3z_r   <= v2z_r;
      p3_yz_r <= rot_y_r * uvz_r;
      p3_zy_r <= rot_z_r * uvy_r;
      p3_zx_r <= rot_z_r * uvx_r;
      p3_xz_r <= rot_x_r * uvz_r;
      p3_xy_r <= rot_x_r * uvy_r;
      p3_yx_r <= rot_y_r * uvx_r;
      pwx_r   <= w2 * uvx_r;
      pwy_r   <= w2 * uvy_r;
      pwz_r   <= w2 * uvz_r;
    end
  end

  // Stage 4: uuv, w term, and the unsaturated sums
  logic signed [P3_W:0]    d3x, d3y, d3z;
  logic signed [UUV_W-1:0] uuvx, uuvy, uuvz;
  logic signed [WT_W-1:0]  wtx, wty, wtz;
  logic signed [SUM_W-1:0] sx_r, sy_r, sz_r;

  assign d3x  = (P3_W+1)'(p3_yz_r) - (P3_W+1)'(p3_zy_r);
  assign d3y  = (P3_W+1)'(p3_zx_r) - (P3_W+1)'(p3_xz_r);
  assign d3z  = (P3_W+1)'(p3_xy_r) - (P3_W+1)'(p3_yx_r);
  assign uuvx = d3x[P3_W:FRAC_W];
  assign uuvy = d3y[P3_W:FRAC_W];
  assign uuvz = d3z[P3_W:FRAC_W];
  assign wtx  = pwx_r[PW_W-1:FRAC_W];
  assign wty  = pwy_r[PW_W-1:FRAC_W];
  assign wtz  = pwz_r[PW_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sx_r <= SUM_W'(v3x_r) + SUM_W'(wtx) + (SUM_W'(uuvx) <<< 1);
      sy_r <= SUM_W'(v3y_r) + SUM_W'(wty) + (SUM_W'(uuvy) <<< 1);
      sz_r <= SUM_W'(v3z_r) + SUM_W'(wtz) + (SUM_W'(uuvz) <<< 1);
    end
  end

  // Stage 5: saturate to the output range
  function automatic logic [VEC_W:0] sat(input logic signed [SUM_W-1:0] s);
    logic [VEC_W:0] res;
    if (s > SUM_W'(VEC_MAX)) begin
      res = {1'b1, VEC_MAX};
    end else if (s < SUM_W'(VEC_MIN)) begin
      res = {1'b1, VEC_MIN};
    end else begin
      res = {1'b0, s[VEC_W-1:0]};
    end
    return res;
  endfunction

  logic [VEC_W:0] satx, saty, satz;
  vec_out_t       res_r;

  assign satx = sat(sx_r);
  assign saty = sat(sy_r);
  assign satz = sat(sz_r);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      res_r.out_x   <= satx[VEC_W-1:0];
      res_r.out_y   <= saty[VEC_W-1:0];
      res_r.out_z   <= satz[VEC_W-1:0];
      res_r.clipped <= satx[VEC_W] | saty[VEC_W] | satz[VEC_W];
    end
  end

  assign out_ch.valid = vld_r[STAGES-1];
  assign out_ch.data  = res_r;

endmodule

### hdl/qvr_checker.sv
`include "assert_macros.svh"

module qvr_checker
  import qvr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VEC_W-1:0] out_x,
  input logic [VEC_W-1:0] out_y,
  input logic [VEC_W-1:0] out_z,
  input logic             clipped
);

  localparam int CNT_W = $clog2(STAGES + 1) + 1;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions inside the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "output valid after reset")
  `ASSERT_IMPLY(a_no_phantom, clk, rst_n, out_valid, inflight_r != '0, "result without input")
  `ASSERT_IMPLY(a_depth, clk, rst_n, 1'b1, inflight_r <= CNT_W'(STAGES), "pipeline overfilled")
  `ASSERT_IMPLY(a_clip_bound, clk, rst_n, out_valid && clipped, out_x == VEC_MAX || out_x == VEC_MIN || out_y == VEC_MAX || out_y == VEC_MIN || out_z == VEC_MAX || out_z == VEC_MIN, "clip flag without bound")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_x, out_y, out_z, clipped}), "stalled result changed")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.data.out_x),
  .out_y     (out_ch.data.out_y),
  .out_z     (out_ch.data.out_z),
  .clipped   (out_ch.data.clipped)
);

### sim/quaternion_vector_rotate_test.sv
module quaternion_vector_rotate_test;
  import qvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int BUSY_PCT    = 74;
  localparam int LIGHT_PCT   = 10;
  localparam int ROUNDS      = 8;
  localparam int ROUND_ITEMS = 85;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Predict rotated vectors and check them in order of arrival
  class rotation_board;
    longint qx, qy, qz, qw;
    vec_out_t expected_rotated[$];
    int errors;

    function new();
      qx = 0;
      qy = 0;
      qz = 0;
      qw = longint'(ROT_W_RESET);
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ROT_W-1:0] val);
      case (idx)
        REG_ROT_X: qx = longint'($signed(val));
        REG_ROT_Y: qy = longint'($signed(val));
        REG_ROT_Z: qz = longint'($signed(val));
        REG_ROT_W: qw = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint clamp(longint a, inout bit clip);
      if (a > longint'(VEC_MAX)) begin
        clip = 1'b1;
        return longint'(VEC_MAX);
      end
      if (a < longint'(VEC_MIN)) begin
        clip = 1'b1;
        return longint'(VEC_MIN);
      end
      return a;
    endfunction

    // v + 2*w*(q x v) + 2*(q x (q x v)), each cross product and w term floored by 14 bits
    function vec_out_t rotate_vector(vec_in_t v);
      longint x, y, z, uvx, uvy, uvz, uuvx, uuvy, uuvz, w2, rx, ry, rz;
      bit clip;
      vec_out_t r;
      x = longint'($signed(v.vec_x));
      y = longint'($signed(v.vec_y));
      z = longint'($signed(v.vec_z));
      uvx = (qy * z - qz * y) >>> FRAC_W;
      uvy = (qz * x - qx * z) >>> FRAC_W;
      uvz = (qx * y - qy * x) >>> FRAC_W;
      uuvx = (qy * uvz - qz * uvy) >>> FRAC_W;
      uuvy = (qz * uvx - qx * uvz) >>> FRAC_W;
      uuvz = (qx * uvy - qy * uvx) >>> FRAC_W;
      w2 = 2 * qw;
      clip = 1'b0;
      rx = clamp(x + ((w2 * uvx) >>> FRAC_W) + 2 * uuvx, clip);
      ry = clamp(y + ((w2 * uvy) >>> FRAC_W) + 2 * uuvy, clip);
      rz = clamp(z + ((w2 * uvz) >>> FRAC_W) + 2 * uuvz, clip);
      r.out_x = rx[VEC_W-1:0];
      r.out_y = ry[VEC_W-1:0];
      r.out_z = rz[VEC_W-1:0];
      r.clipped = clip;
      return r;
    endfunction

    function void note_vector(vec_in_t v);
      expected_rotated.push_back(rotate_vector(v));
    endfunction

    function void check_rotated(vec_out_t got);
      vec_out_t want;
      if (expected_rotated.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d clipped=%0b", $time,
                 $signed(got.out_x), $signed(got.out_y), $signed(got.out_z), got.clipped);
        errors++;
        return;
      end
      want = expected_rotated.pop_front();
      if (got !== want) begin
        $display("%0t: expected x=%0d y=%0d z=%0d clipped=%0b, got x=%0d y=%0d z=%0d clipped=%0b",
                 $time, $signed(want.out_x), $signed(want.out_y), $signed(want.out_z),
                 want.clipped, $signed(got.out_x), $signed(got.out_y), $signed(got.out_z),
                 got.clipped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rotated.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [ROT_W-1:0]     cfg_wdata;

  qvr_stream_if #(.data_t(vec_in_t))  in_ch ();
  qvr_stream_if #(.data_t(vec_out_t)) out_ch ();

  rotation_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  quaternion_vector_rotate DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Note accepted vectors first, then check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_vector(in_ch.data);
      if (out_ch.valid && out_ch.ready) board.check_rotated(out_ch.data);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("quaternion_vector_rotate_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = BUSY_PCT;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = BUSY_PCT;
      end
      IDLE_BOTH: begin
        send_idle_pct = LIGHT_PCT;
        recv_stall_pct = LIGHT_PCT;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Offer one vector, after a random gap, and hold it until accepted
  task automatic send_vector(logic [VEC_W-1:0] x, logic [VEC_W-1:0] y, logic [VEC_W-1:0] z);
    vec_in_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every rotated vector, then let the pipeline empty
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (STAGES + 2) @(posedge clk);
  endtask

  task automatic write_rotation(logic [ROT_W-1:0] x, logic [ROT_W-1:0] y,
                                logic [ROT_W-1:0] z, logic [ROT_W-1:0] w);
    logic [CFG_IDX_W-1:0] idx_list[4];
    logic [ROT_W-1:0] val_list[4];
    idx_list = '{REG_ROT_X, REG_ROT_Y, REG_ROT_Z, REG_ROT_W};
    val_list = '{x, y, z, w};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx_list[i];
      cfg_wdata <= val_list[i];
      board.set_reg(idx_list[i], val_list[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Full-range, moderate or corner component
  function automatic logic [VEC_W-1:0] random_component(int kind);
    logic [VEC_W-1:0] c;
    case (kind)
      0: c = VEC_W'($urandom());
      1: c = VEC_W'($urandom_range(4194303) - 2097152);
      default: begin
        case ($urandom_range(5))
          0: c = VEC_MAX;
          1: c = VEC_MIN;
          2: c = '0;
          3: c = 24'd1;
          4: c = '1;
          default: c = VEC_W'($urandom());
        endcase
      end
    endcase
    return c;
  endfunction

  initial begin
    int kind;
    real a, b, c, d, norm;
    logic [ROT_W-1:0] q[4];
    logic [ROT_W-1:0] corner[4];
    corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000};
    board = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_ROT_X;
    cfg_wdata <= '0;
    set_idling(IDLE_NONE);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity rotation out of reset
    send_vector('0, '0, '0);
    send_vector(VEC_MAX, VEC_MAX, VEC_MAX);
    send_vector(VEC_MIN, VEC_MIN, VEC_MIN);
    send_vector(24'd1, '1, 24'd256);
    finish_phase();

    // Quarter turn about z
    write_rotation(16'd0, 16'd0, 16'd11585, 16'd11585);
    send_vector(24'd256, '0, '0);
    send_vector(VEC_MAX, VEC_MIN, '0);
    send_vector('1, '1, '1);
    finish_phase();

    // Most negative quaternion: heavy overflow and floor of negatives
    write_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vector(VEC_MAX, VEC_MIN, VEC_MAX);
    send_vector(VEC_MIN, VEC_MAX, VEC_MIN);
    send_vector(24'd1, 24'd2, 24'd3);
    finish_phase();

    // Most positive quaternion
    write_rotation(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(VEC_MAX, VEC_MAX, VEC_MIN);
    send_vector('1, 24'd1, '1);
    finish_phase();

    // Zero quaternion passes the vector through unscaled
    write_rotation(16'd0, 16'd0, 16'd0, 16'd0);
    send_vector(24'd123456, -24'sd654321, 24'd777);
    finish_phase();

    // Half turn about x
    write_rotation(16'd16384, 16'd0, 16'd0, 16'd0);
    send_vector(VEC_MIN, VEC_MIN, VEC_MIN);
    send_vector(24'd1000, 24'd2000, -24'sd3000);
    finish_phase();

    // Random rounds: unit, raw and corner quaternions under each idling mode
    for (int r = 0; r < ROUNDS; r++) begin
      case (r % 4)
        1: begin
          for (int i = 0; i < 4; i++) q[i] = ROT_W'($urandom());
        end
        2: begin
          for (int i = 0; i < 4; i++) q[i] = corner[$urandom_range(3)];
        end
        default: begin
          a = ($urandom_range(20000) - 10000.0) / 10000.0;
          b = ($urandom_range(20000) - 10000.0) / 10000.0;
          c = ($urandom_range(20000) - 10000.0) / 10000.0;
          d = ($urandom_range(20000) - 10000.0) / 10000.0;
          norm = $sqrt(a * a + b * b + c * c + d * d);
          if (norm < 0.001) begin
            a = 0.0;
            b = 0.0;
            c = 0.0;
            d = 1.0;
            norm = 1.0;
          end
          q[0] = ROT_W'($rtoi(a / norm * 16384.0));
          q[1] = ROT_W'($rtoi(b / norm * 16384.0));
          q[2] = ROT_W'($rtoi(c / norm * 16384.0));
          q[3] = ROT_W'($rtoi(d / norm * 16384.0));
        end
      endcase
      write_rotation(q[0], q[1], q[2], q[3]);
      set_idling(idle_mode_e'(r / 2));
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        kind = $urandom_range(2);
        send_vector(random_component(kind), random_component(kind), random_component(kind));
      end
      finish_phase();
    end

    board.errors += board.pending();
    if (board.errors == 0) begin
      $display("quaternion_vector_rotate_test: done, clean");
    end else begin
      $display("quaternion_vector_rotate_test: done, errors");
    end
    $finish;
  end

endmodule
